// ----- rtl/prq_pkg.sv -----
package prq_pkg;

    localparam int LEVELS_DEF  = 32;
    localparam int THREADS_DEF = 16;

    localparam int ID_W   = 4;
    localparam int PRIO_W = 5;
    localparam int MAP_W  = 32;
    localparam int OP_W   = 2;
    localparam int STAT_W = 2;

    localparam logic [OP_W-1:0] OP_INSERT   = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE   = 2'd1;
    localparam logic [OP_W-1:0] OP_SCHEDULE = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_IGNORED = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY   = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [ID_W-1:0]   thread_id;
        logic [PRIO_W-1:0] priority_req;
    } t_req;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic              switch_now;
        logic              from_valid;
        logic [ID_W-1:0]   old_thread;
        logic [ID_W-1:0]   new_thread;
        logic [PRIO_W-1:0] to_priority;
        logic [MAP_W-1:0]  ready_levels;
    } t_resp;

    typedef struct packed {
        logic idle;
        logic done;
    } t_eng_stat;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INS_RD,
        ST_INS_LINK,
        ST_INS_SELF,
        ST_REM_RD,
        ST_REM_HT,
        ST_REM_LINK,
        ST_SCH_RD,
        ST_SCH_PICK,
        ST_DONE
    } t_state;

endpackage

// ----- rtl/prq_ffs.sv -----
module prq_ffs #(
    parameter int LEVELS = prq_pkg::LEVELS_DEF
) (
    input  logic [LEVELS-1:0]         i_map,
    output logic                      o_found,
    output logic [$clog2(LEVELS)-1:0] o_index
);

    localparam int LW = $clog2(LEVELS);

    // Scanning downwards lets the lowest set bit win.
    always_comb begin
        o_found = 1'b0;
        o_index = '0;
        for (int i = LEVELS - 1; i >= 0; i--) begin
            if (i_map[i]) begin
                o_found = 1'b1;
                o_index = LW'(i);
            end
        end
    end

endmodule

// ----- rtl/prq_engine.sv -----
module prq_engine #(
    parameter int LEVELS  = prq_pkg::LEVELS_DEF,
    parameter int THREADS = prq_pkg::THREADS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  prq_pkg::t_req       i_req,
    input  logic                i_take,
    output prq_pkg::t_eng_stat  o_stat,
    output prq_pkg::t_resp      o_resp
);

    localparam int LW = $clog2(LEVELS);
    localparam int TW = $clog2(THREADS);

    prq_pkg::t_state r_state, n_state;

    // List store: one write and one registered read per memory per cycle.
    logic [TW-1:0] head_mem [LEVELS];
    logic [TW-1:0] tail_mem [LEVELS];
    logic [TW-1:0] next_mem [THREADS];
    logic [TW-1:0] prev_mem [THREADS];
    logic [LW-1:0] lvl_mem  [THREADS];

    logic [TW-1:0] r_head_rd, r_tail_rd, r_next_rd, r_prev_rd;
    logic [LW-1:0] r_lvl_rd;

    logic          head_we, tail_we, next_we, prev_we, lvl_we;
    logic [TW-1:0] head_wd, tail_wd, next_wd, prev_wd;
    logic [TW-1:0] next_wa, prev_wa;
    logic [LW-1:0] lt_ra;

    logic [LEVELS-1:0]  r_bitmap;
    logic [THREADS-1:0] r_queued;
    logic [TW-1:0]      r_run_thread;
    logic               r_run_valid;

    logic [prq_pkg::OP_W-1:0]   r_op;
    logic [TW-1:0]              r_tid;
    logic [LW-1:0]              r_lvl;
    logic [TW-1:0]              r_nx, r_pv;
    logic [prq_pkg::STAT_W-1:0] r_status;
    logic                       r_sw, r_fv;
    logic [TW-1:0]              r_ft, r_tt;
    logic [LW-1:0]              r_tp;

    logic [31:0]                tid_ext, pr_ext;
    logic [TW-1:0]              tidx;
    logic [LW-1:0]              plvl;
    logic                       t_ok, p_ok;
    logic                       ffs_found;
    logic [LW-1:0]              ffs_idx;
    logic [prq_pkg::STAT_W-1:0] start_status;
    logic                       start_work;
    logic                       is_head, is_tail, lvl_busy, pick_switch;
    logic [31:0]                ft_ext, tt_ext, tp_ext, map_ext;

    prq_ffs #(.LEVELS(LEVELS)) u_ffs (
        .i_map   (r_bitmap),
        .o_found (ffs_found),
        .o_index (ffs_idx)
    );

    assign tid_ext = 32'(i_req.thread_id);
    assign pr_ext  = 32'(i_req.priority_req);
    assign tidx    = tid_ext[TW-1:0];
    assign plvl    = pr_ext[LW-1:0];
    assign t_ok    = tid_ext < 32'(THREADS);
    assign p_ok    = pr_ext < 32'(LEVELS);

    assign is_head     = r_head_rd == r_tid;
    assign is_tail     = r_tail_rd == r_tid;
    assign lvl_busy    = r_bitmap[r_lvl];
    assign pick_switch = !r_run_valid || (r_run_thread != r_head_rd);

    always_comb begin
        start_status = prq_pkg::STAT_IGNORED;
        start_work   = 1'b0;
        case (i_req.op)
            prq_pkg::OP_INSERT: begin
                if (t_ok && p_ok && !r_queued[tidx]) begin
                    start_status = prq_pkg::STAT_OK;
                    start_work   = 1'b1;
                end
            end
            prq_pkg::OP_REMOVE: begin
                if (t_ok && r_queued[tidx]) begin
                    start_status = prq_pkg::STAT_OK;
                    start_work   = 1'b1;
                end
            end
            prq_pkg::OP_SCHEDULE: begin
                start_status = ffs_found ? prq_pkg::STAT_OK : prq_pkg::STAT_EMPTY;
                start_work   = ffs_found;
            end
            default: begin
                start_status = prq_pkg::STAT_IGNORED;
            end
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            prq_pkg::ST_IDLE: begin
                if (i_start) begin
                    if (!start_work) begin
                        n_state = prq_pkg::ST_DONE;
                    end else if (i_req.op == prq_pkg::OP_INSERT) begin
                        n_state = prq_pkg::ST_INS_RD;
                    end else if (i_req.op == prq_pkg::OP_REMOVE) begin
                        n_state = prq_pkg::ST_REM_RD;
                    end else begin
                        n_state = prq_pkg::ST_SCH_RD;
                    end
                end
            end
            prq_pkg::ST_INS_RD:   n_state = prq_pkg::ST_INS_LINK;
            prq_pkg::ST_INS_LINK: n_state = prq_pkg::ST_INS_SELF;
            prq_pkg::ST_INS_SELF: n_state = prq_pkg::ST_DONE;
            prq_pkg::ST_REM_RD:   n_state = prq_pkg::ST_REM_HT;
            prq_pkg::ST_REM_HT:   n_state = prq_pkg::ST_REM_LINK;
            prq_pkg::ST_REM_LINK: n_state = prq_pkg::ST_DONE;
            prq_pkg::ST_SCH_RD:   n_state = prq_pkg::ST_SCH_PICK;
            prq_pkg::ST_SCH_PICK: n_state = prq_pkg::ST_DONE;
            prq_pkg::ST_DONE: begin
                if (i_take) begin
                    n_state = prq_pkg::ST_IDLE;
                end
            end
            default: n_state = prq_pkg::ST_IDLE;
        endcase
    end

    // Store port control.
    always_comb begin
        head_we = 1'b0;
        tail_we = 1'b0;
        next_we = 1'b0;
        prev_we = 1'b0;
        lvl_we  = 1'b0;
        head_wd = r_tid;
        tail_wd = r_tid;
        next_wd = r_tid;
        prev_wd = r_tid;
        next_wa = r_tid;
        prev_wa = r_tid;
        lt_ra   = r_lvl;
        o_stat.idle = 1'b0;
        o_stat.done = 1'b0;
        unique case (r_state)
            prq_pkg::ST_IDLE: o_stat.idle = 1'b1;
            prq_pkg::ST_INS_LINK: begin
                tail_we = 1'b1;
                prev_we = 1'b1;
                lvl_we  = 1'b1;
                if (lvl_busy) begin
                    next_we = 1'b1;
                    next_wa = r_tail_rd;
                    prev_wd = r_tail_rd;
                end else begin
                    head_we = 1'b1;
                end
            end
            prq_pkg::ST_INS_SELF: next_we = 1'b1;
            prq_pkg::ST_REM_HT:   lt_ra = r_lvl_rd;
            prq_pkg::ST_REM_LINK: begin
                head_wd = r_nx;
                tail_wd = r_pv;
                next_wa = r_pv;
                next_wd = r_nx;
                prev_wa = r_nx;
                prev_wd = r_pv;
                head_we = is_head;
                next_we = !is_head;
                tail_we = is_tail;
                prev_we = !is_tail;
            end
            prq_pkg::ST_DONE: o_stat.done = 1'b1;
            default: o_stat.idle = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_head_rd <= head_mem[lt_ra];
        r_tail_rd <= tail_mem[lt_ra];
        r_next_rd <= next_mem[r_tid];
        r_prev_rd <= prev_mem[r_tid];
        r_lvl_rd  <= lvl_mem[r_tid];
        if (head_we) begin
            head_mem[r_lvl] <= head_wd;
        end
        if (tail_we) begin
            tail_mem[r_lvl] <= tail_wd;
        end
        if (next_we) begin
            next_mem[next_wa] <= next_wd;
        end
        if (prev_we) begin
            prev_mem[prev_wa] <= prev_wd;
        end
        if (lvl_we) begin
            lvl_mem[r_tid] <= r_lvl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= prq_pkg::ST_IDLE;
            r_bitmap     <= '0;
            r_queued     <= '0;
            r_run_thread <= '0;
            r_run_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == prq_pkg::ST_INS_LINK) begin
                r_bitmap[r_lvl] <= 1'b1;
                r_queued[r_tid] <= 1'b1;
            end
            if (r_state == prq_pkg::ST_REM_LINK) begin
                r_queued[r_tid] <= 1'b0;
                if (is_head && is_tail) begin
                    r_bitmap[r_lvl] <= 1'b0;
                end
            end
            if (r_state == prq_pkg::ST_SCH_PICK && pick_switch) begin
                r_run_thread <= r_head_rd;
                r_run_valid  <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == prq_pkg::ST_IDLE && i_start) begin
            r_op     <= i_req.op;
            r_tid    <= tidx;
            r_lvl    <= (i_req.op == prq_pkg::OP_SCHEDULE) ? ffs_idx : plvl;
            r_status <= start_status;
            r_sw     <= 1'b0;
            r_fv     <= 1'b0;
            r_ft     <= '0;
            r_tt     <= '0;
            r_tp     <= '0;
        end
        if (r_state == prq_pkg::ST_REM_HT) begin
            r_lvl <= r_lvl_rd;
            r_nx  <= r_next_rd;
            r_pv  <= r_prev_rd;
        end
        if (r_state == prq_pkg::ST_SCH_PICK && r_op == prq_pkg::OP_SCHEDULE) begin
            r_tt <= r_head_rd;
            r_tp <= r_lvl;
            if (pick_switch) begin
                r_sw <= 1'b1;
                r_fv <= r_run_valid;
                r_ft <= r_run_valid ? r_run_thread : '0;
            end
        end
    end

    assign ft_ext  = 32'(r_ft);
    assign tt_ext  = 32'(r_tt);
    assign tp_ext  = 32'(r_tp);
    assign map_ext = 32'(r_bitmap);

    always_comb begin
        o_resp.status       = r_status;
        o_resp.switch_now   = r_sw;
        o_resp.from_valid   = r_fv;
        o_resp.old_thread   = ft_ext[prq_pkg::ID_W-1:0];
        o_resp.new_thread   = tt_ext[prq_pkg::ID_W-1:0];
        o_resp.to_priority  = tp_ext[prq_pkg::PRIO_W-1:0];
        o_resp.ready_levels = map_ext;
    end

endmodule

// ----- rtl/priority_ready_queue_scheduler_unit.sv -----
// Ready-queue scheduler: one FIFO of threads per priority level, with a
// ready bitmap and a find-first-set pick of the most urgent level.
// Request channel (i_req_valid / o_req_ready / i_req) carries insert,
// remove and schedule requests; response channel (o_resp_valid /
// i_resp_ready / o_resp) returns exactly one response per request.
// Each request is worked through by a small sequencer over the list
// store, whose memories each take one write and one registered read per
// cycle. A rejected request or an empty schedule goes straight to done;
// otherwise the sequencer steps through read, then pick (schedule), link
// and self-link (insert) or head/tail and link (remove). o_req_ready is
// high only while it is idle, so it takes one request at a time.
// The response sits in an output register; while the receiver stalls,
// one further request can be accepted and worked through, and its
// response then waits in the sequencer until the output register frees.
// Reset clears the ready bitmap, the queued flags and the current thread;
// the list memories need no clearing, so the block is ready as soon as
// reset is released.
module priority_ready_queue_scheduler_unit #(
    parameter int LEVELS  = prq_pkg::LEVELS_DEF,
    parameter int THREADS = prq_pkg::THREADS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    output logic           o_req_ready,
    input  prq_pkg::t_req  i_req,
    output logic           o_resp_valid,
    input  logic           i_resp_ready,
    output prq_pkg::t_resp o_resp
);

    prq_pkg::t_eng_stat eng_stat;
    prq_pkg::t_resp     eng_resp;
    logic               eng_start, eng_take;
    logic               r_out_valid;
    prq_pkg::t_resp     r_out;

    assign o_req_ready = eng_stat.idle;
    assign eng_start   = i_req_valid && eng_stat.idle;
    assign eng_take    = eng_stat.done && (!r_out_valid || i_resp_ready);

    prq_engine #(.LEVELS(LEVELS), .THREADS(THREADS)) u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (eng_start),
        .i_req   (i_req),
        .i_take  (eng_take),
        .o_stat  (eng_stat),
        .o_resp  (eng_resp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (eng_take) begin
            r_out_valid <= 1'b1;
        end else if (i_resp_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (eng_take) begin
            r_out <= eng_resp;
        end
    end

    assign o_resp_valid = r_out_valid;
    assign o_resp       = r_out;

endmodule

// ----- rtl/prq_chk.sv -----
module prq_chk (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_req_valid,
    input logic           o_req_ready,
    input prq_pkg::t_req  i_req,
    input logic           o_resp_valid,
    input logic           i_resp_ready,
    input prq_pkg::t_resp o_resp
);

    // Reset empties the response register.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_resp_valid)
        else $error("response valid after reset");

    // An accepted request leaves the sequencer busy in the following cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && o_req_ready |=> !o_req_ready)
        else $error("ready stayed high after a request was accepted");

    // Nothing to schedule means the bitmap is empty.
    a_empty_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_resp_valid && o_resp.status == prq_pkg::STAT_EMPTY
        |-> o_resp.ready_levels == '0)
        else $error("empty schedule with ready levels set");

    // A switch always lands on a level that is ready.
    a_switch_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_resp_valid && o_resp.switch_now
        |-> o_resp.status == prq_pkg::STAT_OK && o_resp.ready_levels[o_resp.to_priority])
        else $error("switch to a level that is not ready");

    a_resp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_resp_valid && !i_resp_ready |=> o_resp_valid && $stable(o_resp))
        else $error("stalled response changed");

endmodule

bind priority_ready_queue_scheduler_unit prq_chk u_prq_chk (.*);

// ----- tb/tb_priority_ready_queue_scheduler_unit.sv -----
module tb_priority_ready_queue_scheduler_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [prq_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE_TICKS = 20;
    localparam int CHUNKS       = 14;
    localparam int CHUNK_LEN    = 75;

    typedef struct {
        prq_pkg::t_req req;
        bit            hold;
        int unsigned   mode;
    } t_sched_cmd;

    logic            i_clk;
    logic            i_rst_n      = 1'b0;
    logic            i_req_valid  = 1'b0;
    logic            o_req_ready;
    prq_pkg::t_req   i_req        = '0;
    logic            o_resp_valid;
    logic            i_resp_ready = 1'b1;
    prq_pkg::t_resp  o_resp;

    // Idle percentages per phase: none, sender, receiver, both.
    int unsigned send_gap_pct[4]   = '{0, 62, 0, 33};
    int unsigned recv_stall_pct[4] = '{0, 0, 62, 33};

    t_sched_cmd      cmd_backlog[$];
    prq_pkg::t_resp  resp_expected[$];
    logic [prq_pkg::THREADS_DEF-1:0] plan_queued = '0;

    // Shadow of the scheduler state.
    logic [prq_pkg::MAP_W-1:0]  lvl_map = '0;
    logic [prq_pkg::ID_W-1:0]   lvl_first [prq_pkg::LEVELS_DEF];
    logic [prq_pkg::ID_W-1:0]   lvl_last  [prq_pkg::LEVELS_DEF];
    int unsigned                lvl_depth [prq_pkg::LEVELS_DEF];
    logic [prq_pkg::ID_W-1:0]   link_fwd  [prq_pkg::THREADS_DEF];
    logic [prq_pkg::ID_W-1:0]   link_back [prq_pkg::THREADS_DEF];
    logic [prq_pkg::PRIO_W-1:0] thr_level [prq_pkg::THREADS_DEF];
    logic [prq_pkg::THREADS_DEF-1:0] thr_queued = '0;
    logic [prq_pkg::ID_W-1:0]   cur_thr = '0;
    logic                       cur_ok  = 1'b0;
    logic [prq_pkg::PRIO_W-1:0] cur_lvl = prq_pkg::PRIO_W'(prq_pkg::LEVELS_DEF - 1);

    logic        req_taken = 1'b0;
    int unsigned idle_mode = 0;
    int unsigned fail_count = 0;
    int unsigned cycle_count = 0;
    int unsigned accepted_count = 0;
    int unsigned resp_count = 0;
    int unsigned switch_count = 0;
    int unsigned ignored_count = 0;
    int unsigned empty_count = 0;
    int unsigned deepest = 0;

    priority_ready_queue_scheduler_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_req_valid),
        .o_req_ready  (o_req_ready),
        .i_req        (i_req),
        .o_resp_valid (o_resp_valid),
        .i_resp_ready (i_resp_ready),
        .o_resp       (o_resp)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH: %s", msg);
        fail_count++;
    endtask

    task automatic predict_response(input prq_pkg::t_req rq, output prq_pkg::t_resp rs);
        logic [prq_pkg::ID_W-1:0]   t;
        logic [prq_pkg::ID_W-1:0]   nx;
        logic [prq_pkg::ID_W-1:0]   pv;
        logic [prq_pkg::PRIO_W-1:0] p;
        logic [prq_pkg::PRIO_W-1:0] l;
        bit                         found;
        bit                         is_head;
        bit                         is_tail;
        rs = '0;
        t = rq.thread_id;
        p = rq.priority_req;
        case (rq.op)
            prq_pkg::OP_INSERT: begin
                if (thr_queued[t]) begin
                    rs.status = prq_pkg::STAT_IGNORED;
                end else begin
                    if (lvl_map[p]) begin
                        link_fwd[lvl_last[p]] = t;
                        link_back[t] = lvl_last[p];
                    end else begin
                        lvl_first[p] = t;
                        link_back[t] = t;
                        lvl_map[p] = 1'b1;
                        lvl_depth[p] = 0;
                    end
                    link_fwd[t] = t;
                    lvl_last[p] = t;
                    thr_level[t] = p;
                    thr_queued[t] = 1'b1;
                    lvl_depth[p]++;
                    if (lvl_depth[p] > deepest) deepest = lvl_depth[p];
                end
            end
            prq_pkg::OP_REMOVE: begin
                if (!thr_queued[t]) begin
                    rs.status = prq_pkg::STAT_IGNORED;
                end else begin
                    l = thr_level[t];
                    nx = link_fwd[t];
                    pv = link_back[t];
                    is_head = (lvl_first[l] == t);
                    is_tail = (lvl_last[l] == t);
                    if (is_head) lvl_first[l] = nx;
                    else link_fwd[pv] = nx;
                    if (is_tail) lvl_last[l] = pv;
                    else link_back[nx] = pv;
                    if (is_head && is_tail) lvl_map[l] = 1'b0;
                    thr_queued[t] = 1'b0;
                    lvl_depth[l]--;
                end
            end
            prq_pkg::OP_SCHEDULE: begin
                found = 1'b0;
                l = '0;
                // Scanning downwards leaves the most urgent ready level in l.
                for (int i = prq_pkg::LEVELS_DEF - 1; i >= 0; i--) begin
                    if (lvl_map[i]) begin
                        l = prq_pkg::PRIO_W'(i);
                        found = 1'b1;
                    end
                end
                if (!found) begin
                    rs.status = prq_pkg::STAT_EMPTY;
                end else begin
                    rs.new_thread = lvl_first[l];
                    rs.to_priority = l;
                    if (!cur_ok || cur_thr != lvl_first[l]) begin
                        rs.switch_now = 1'b1;
                        rs.from_valid = cur_ok;
                        rs.old_thread = cur_ok ? cur_thr : '0;
                        cur_thr = lvl_first[l];
                        cur_ok = 1'b1;
                        cur_lvl = l;
                    end
                end
            end
            default: rs.status = prq_pkg::STAT_IGNORED;
        endcase
        rs.ready_levels = lvl_map;
    endtask

    task automatic check_response(input prq_pkg::t_resp got);
        prq_pkg::t_resp want;
        if (resp_expected.size() == 0) begin
            report_mismatch($sformatf("response %h with no request outstanding", got));
            return;
        end
        want = resp_expected.pop_front();
        if (got.status !== want.status)
            report_mismatch($sformatf("response %0d status: got %0d, expected %0d",
                resp_count, got.status, want.status));
        if (got.switch_now !== want.switch_now)
            report_mismatch($sformatf("response %0d switch_now: got %b, expected %b",
                resp_count, got.switch_now, want.switch_now));
        if (got.from_valid !== want.from_valid)
            report_mismatch($sformatf("response %0d from_valid: got %b, expected %b",
                resp_count, got.from_valid, want.from_valid));
        if (got.old_thread !== want.old_thread)
            report_mismatch($sformatf("response %0d old_thread: got %0d, expected %0d",
                resp_count, got.old_thread, want.old_thread));
        if (got.new_thread !== want.new_thread)
            report_mismatch($sformatf("response %0d new_thread: got %0d, expected %0d",
                resp_count, got.new_thread, want.new_thread));
        if (got.to_priority !== want.to_priority)
            report_mismatch($sformatf("response %0d to_priority: got %0d, expected %0d",
                resp_count, got.to_priority, want.to_priority));
        if (got.ready_levels !== want.ready_levels)
            report_mismatch($sformatf("response %0d ready_levels: got %h, expected %h",
                resp_count, got.ready_levels, want.ready_levels));
        resp_count++;
    endtask

    // The plan tracks which threads will be queued, so that most requests
    // are meaningful while the rest are deliberately inconsistent.
    function automatic void plan_req(input logic [prq_pkg::OP_W-1:0] op,
                                     input logic [prq_pkg::ID_W-1:0] tid,
                                     input logic [prq_pkg::PRIO_W-1:0] prio, input bit hold,
                                     input int unsigned mode);
        t_sched_cmd cmd;
        cmd.req.op = op;
        cmd.req.thread_id = tid;
        cmd.req.priority_req = prio;
        cmd.hold = hold;
        cmd.mode = mode;
        if (op == prq_pkg::OP_INSERT) plan_queued[tid] = 1'b1;
        if (op == prq_pkg::OP_REMOVE) plan_queued[tid] = 1'b0;
        cmd_backlog.push_back(cmd);
    endfunction

    function automatic logic [prq_pkg::ID_W-1:0] pick_thread(input bit want_queued);
        logic [prq_pkg::ID_W-1:0] t;
        do t = prq_pkg::ID_W'($urandom_range(0, prq_pkg::THREADS_DEF - 1));
        while (plan_queued[t] != want_queued);
        return t;
    endfunction

    // Request driver and response receiver.
    always @(negedge i_clk) begin
        t_sched_cmd cmd;
        bit         launch;
        i_resp_ready <= ($urandom_range(0, 99) >= recv_stall_pct[idle_mode]);
        if (i_rst_n && (!i_req_valid || req_taken)) begin
            launch = 1'b0;
            if (cmd_backlog.size() != 0) begin
                idle_mode = cmd_backlog[0].mode;
                if (!(cmd_backlog[0].hold && resp_expected.size() != 0) &&
                    $urandom_range(0, 99) >= send_gap_pct[idle_mode])
                    launch = 1'b1;
            end
            if (launch) begin
                cmd = cmd_backlog.pop_front();
                i_req <= cmd.req;
            end
            i_req_valid <= launch;
        end
    end

    // Monitor: predict on each accepted request, check each accepted response.
    always @(posedge i_clk) begin
        prq_pkg::t_resp want;
        if (!i_rst_n) begin
            req_taken <= 1'b0;
        end else begin
            req_taken <= i_req_valid && o_req_ready;
            if (o_resp_valid && i_resp_ready) check_response(o_resp);
            if (i_req_valid && o_req_ready) begin
                predict_response(i_req, want);
                resp_expected.push_back(want);
                accepted_count++;
                if (want.switch_now) switch_count++;
                if (want.status == prq_pkg::STAT_IGNORED) ignored_count++;
                if (want.status == prq_pkg::STAT_EMPTY) empty_count++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        int unsigned                r;
        int unsigned                mode;
        bit                         hold;
        logic [prq_pkg::PRIO_W-1:0] pr;
        logic [prq_pkg::ID_W-1:0]   tid;

        // Directed opening: empty and inconsistent requests, extremes of the
        // fields, removal of the head, middle and tail, and of the current thread.
        plan_req(prq_pkg::OP_SCHEDULE, 4'd9, 5'd17, 1'b0, 0);
        plan_req(prq_pkg::OP_REMOVE, 4'd5, 5'd0, 1'b0, 0);
        plan_req(OP_UNUSED, 4'd15, 5'd31, 1'b0, 0);
        plan_req(prq_pkg::OP_INSERT, 4'd0, 5'd31, 1'b0, 0);
        plan_req(prq_pkg::OP_INSERT, 4'd15, 5'd0, 1'b0, 0);
        plan_req(prq_pkg::OP_INSERT, 4'd0, 5'd5, 1'b0, 0);
        plan_req(prq_pkg::OP_SCHEDULE, 4'd0, 5'd0, 1'b0, 0);
        plan_req(prq_pkg::OP_SCHEDULE, 4'd15, 5'd31, 1'b0, 0);
        plan_req(prq_pkg::OP_INSERT, 4'd3, 5'd0, 1'b0, 0);
        plan_req(prq_pkg::OP_INSERT, 4'd7, 5'd0, 1'b0, 0);
        plan_req(prq_pkg::OP_REMOVE, 4'd15, 5'd0, 1'b0, 0);
        plan_req(prq_pkg::OP_SCHEDULE, 4'd0, 5'd0, 1'b0, 0);
        plan_req(prq_pkg::OP_REMOVE, 4'd7, 5'd0, 1'b0, 0);
        plan_req(prq_pkg::OP_INSERT, 4'd9, 5'd0, 1'b0, 0);
        plan_req(prq_pkg::OP_INSERT, 4'd10, 5'd0, 1'b0, 0);
        plan_req(prq_pkg::OP_REMOVE, 4'd9, 5'd0, 1'b0, 0);
        plan_req(prq_pkg::OP_REMOVE, 4'd3, 5'd0, 1'b0, 0);
        plan_req(prq_pkg::OP_SCHEDULE, 4'd0, 5'd0, 1'b0, 0);
        plan_req(prq_pkg::OP_REMOVE, 4'd10, 5'd0, 1'b0, 0);
        plan_req(prq_pkg::OP_SCHEDULE, 4'd0, 5'd0, 1'b0, 0);
        plan_req(prq_pkg::OP_REMOVE, 4'd0, 5'd0, 1'b0, 0);
        plan_req(prq_pkg::OP_SCHEDULE, 4'd6, 5'd12, 1'b0, 0);

        for (int c = 0; c < CHUNKS; c++) begin
            for (int k = 0; k < CHUNK_LEN; k++) begin
                r = $urandom_range(0, 99);
                // Half the chunks crowd a few levels so that queues grow long.
                if (c % 2) pr = prq_pkg::PRIO_W'($urandom_range(0, 31));
                else if ($urandom_range(0, 1)) pr = prq_pkg::PRIO_W'($urandom_range(0, 2));
                else pr = prq_pkg::PRIO_W'($urandom_range(29, 31));
                tid = prq_pkg::ID_W'($urandom_range(0, prq_pkg::THREADS_DEF - 1));
                hold = (k == 0);
                mode = c % 4;
                if (r < 10) begin
                    case (r % 3)
                        0: if (plan_queued != '0)
                            plan_req(prq_pkg::OP_INSERT, pick_thread(1'b1), pr, hold, mode);
                        else plan_req(OP_UNUSED, tid, pr, hold, mode);
                        1: if (plan_queued != '1)
                            plan_req(prq_pkg::OP_REMOVE, pick_thread(1'b0), pr, hold, mode);
                        else plan_req(OP_UNUSED, tid, pr, hold, mode);
                        default: plan_req(OP_UNUSED, tid, pr, hold, mode);
                    endcase
                end else if (r < 45 && plan_queued != '1) begin
                    plan_req(prq_pkg::OP_INSERT, pick_thread(1'b0), pr, hold, mode);
                end else if (r < 75 && plan_queued != '0) begin
                    plan_req(prq_pkg::OP_REMOVE, pick_thread(1'b1), pr, hold, mode);
                end else begin
                    plan_req(prq_pkg::OP_SCHEDULE, tid, pr, hold, mode);
                end
            end
        end

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (cmd_backlog.size() != 0 || i_req_valid) @(negedge i_clk);
        while (resp_expected.size() != 0) @(negedge i_clk);
        repeat (SETTLE_TICKS) @(negedge i_clk);

        $display("Run covered %0d requests and %0d responses: %0d switches, %0d ignored,",
            accepted_count, resp_count, switch_count, ignored_count);
        $display("%0d schedules with nothing ready, longest level queue %0d threads.",
            empty_count, deepest);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
